/* sv/hpr_pkg.sv */
`timescale 1ns / 1ps
// Package for the HTTP request header parser: parser states, result codes,
// context and result structs, character classes. No dependencies.
package hpr_pkg;

    typedef enum logic [4:0] {
        ST_METHOD_START = 5'd0,
        ST_METHOD       = 5'd1,
        ST_URI          = 5'd2,
        ST_VER_H        = 5'd3,
        ST_VER_T1       = 5'd4,
        ST_VER_T2       = 5'd5,
        ST_VER_P        = 5'd6,
        ST_VER_SLASH    = 5'd7,
        ST_MAJOR_START  = 5'd8,
        ST_MAJOR        = 5'd9,
        ST_MINOR_START  = 5'd10,
        ST_MINOR        = 5'd11,
        ST_NL1          = 5'd12,
        ST_LINE_START   = 5'd13,
        ST_LWS          = 5'd14,
        ST_NAME         = 5'd15,
        ST_SP_VALUE     = 5'd16,
        ST_VALUE        = 5'd17,
        ST_NL2          = 5'd18,
        ST_NL3          = 5'd19
    } t_state;

    typedef enum logic [1:0] {
        STS_PENDING = 2'd0,
        STS_GOOD    = 2'd1,
        STS_BAD     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ROLE_OTHER  = 3'd0,
        ROLE_METHOD = 3'd1,
        ROLE_URI    = 3'd2,
        ROLE_NAME   = 3'd3,
        ROLE_VALUE  = 3'd4
    } t_role;

    typedef struct packed {
        t_state     state;
        logic       seen_header;
        logic [2:0] match_pos;
        logic       is_host;
        logic [7:0] major;
        logic [7:0] minor;
    } t_ctx;

    localparam t_ctx CTX_RESET = '{
        state:       ST_METHOD_START,
        seen_header: 1'b0,
        match_pos:   3'd0,
        is_host:     1'b0,
        major:       8'd0,
        minor:       8'd0
    };

    typedef struct packed {
        t_status    status;
        t_role      role;
        logic       header_begin;
        logic       host_value_byte;
        logic [7:0] major;
        logic [7:0] minor;
    } t_res;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CTL_MAX  = 8'd31;
    localparam logic [2:0] HOST_LEN = 3'd4;

    localparam logic [7:0] HOST_TEXT [4] = '{8'h48, 8'h6F, 8'h73, 8'h74};

    function automatic logic is_ctl(input logic [7:0] b);
        return (b <= CTL_MAX) || (b == CH_DEL);
    endfunction

    function automatic logic is_sep(input logic [7:0] b);
        logic r;
        case (b) inside
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
            8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_token(input logic [7:0] b);
        return !b[7] && !is_ctl(b) && !is_sep(b);
    endfunction

    function automatic logic is_dec(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic [7:0] add_digit(input logic [7:0] v, input logic [7:0] b);
        logic [11:0] n;
        n = ({4'd0, v} * 12'd10) + {8'd0, b[3:0]};
        return (n > 12'd255) ? 8'hFF : n[7:0];
    endfunction

endpackage

/* sv/http_request_header_parser_core.sv */
`timescale 1ns / 1ps
// Top level of the HTTP request header parser: input register, parser
// context, result register. Depends on hpr_pkg and hpr_step.
//
//  channel  | dir | tdata                         | tuser
//  s_axis   | in  | [7:0] data_byte               | [0] start_of_request
//  m_axis   | out | [1:0] status, [4:2] byte_role,| -
//           |     | [5] header_begin, [6] host_value_byte,
//           |     | [14:7] version_major, [22:15] version_minor, [23] zero
//
// One word in, one word out; a word may enter every cycle while the output is not stalled.
// Each word passes the input register, then the parser step into the
// result register, which also updates the parser context.
// A stalled output holds the result; the input register holds one more word.
// i_rst_n clears the context to method start and empties both registers.
module http_request_header_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] start_of_request
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // status, byte_role, header_begin,
                                        // host_value_byte, version_major,
                                        // version_minor, zero pad
);

    logic          r_in_vld;
    logic [7:0]    r_in_byte;
    logic          r_in_sor;
    hpr_pkg::t_ctx r_ctx;
    logic          r_out_vld;
    hpr_pkg::t_res r_out;

    hpr_pkg::t_ctx n_ctx;
    hpr_pkg::t_res n_out;
    logic          adv;

    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;

    hpr_step u_step (
        .i_ctx  (r_ctx),
        .i_byte (r_in_byte),
        .i_sor  (r_in_sor),
        .o_ctx  (n_ctx),
        .o_res  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_sor  <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx     <= hpr_pkg::CTX_RESET;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_ctx     <= n_ctx;
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out.minor, r_out.major, r_out.host_value_byte,
                            r_out.header_begin, r_out.role, r_out.status};

endmodule

/* sv/hpr_step.sv */
`timescale 1ns / 1ps
// One parser step: next context and per-byte result from the current context
// (the reset context at start of request) and one byte. Depends on hpr_pkg.
module hpr_step (
    input  hpr_pkg::t_ctx i_ctx,
    input  logic [7:0]    i_byte,
    input  logic          i_sor,
    output hpr_pkg::t_ctx o_ctx,
    output hpr_pkg::t_res o_res
);

    hpr_pkg::t_ctx    c;
    hpr_pkg::t_ctx    n_raw;
    hpr_pkg::t_status sts;
    hpr_pkg::t_role   role;
    logic             hbegin;
    logic             hval;
    logic [7:0]       b;

    assign c = i_sor ? hpr_pkg::CTX_RESET : i_ctx;
    assign b = i_byte;

    always_comb begin
        n_raw = c;
        unique case (c.state)
            hpr_pkg::ST_METHOD_START: begin
                if (hpr_pkg::is_token(b)) n_raw.state = hpr_pkg::ST_METHOD;
            end
            hpr_pkg::ST_METHOD: begin
                if (b == hpr_pkg::CH_SP) n_raw.state = hpr_pkg::ST_URI;
            end
            hpr_pkg::ST_URI: begin
                if (b == hpr_pkg::CH_SP) n_raw.state = hpr_pkg::ST_VER_H;
            end
            hpr_pkg::ST_VER_H: begin
                if (b == hpr_pkg::CH_H) n_raw.state = hpr_pkg::ST_VER_T1;
            end
            hpr_pkg::ST_VER_T1: begin
                if (b == hpr_pkg::CH_T) n_raw.state = hpr_pkg::ST_VER_T2;
            end
            hpr_pkg::ST_VER_T2: begin
                if (b == hpr_pkg::CH_T) n_raw.state = hpr_pkg::ST_VER_P;
            end
            hpr_pkg::ST_VER_P: begin
                if (b == hpr_pkg::CH_P) n_raw.state = hpr_pkg::ST_VER_SLASH;
            end
            hpr_pkg::ST_VER_SLASH: begin
                if (b == hpr_pkg::CH_SLASH) begin
                    n_raw.major = 8'd0;
                    n_raw.minor = 8'd0;
                    n_raw.state = hpr_pkg::ST_MAJOR_START;
                end
            end
            hpr_pkg::ST_MAJOR_START: begin
                if (hpr_pkg::is_dec(b)) begin
                    n_raw.major = hpr_pkg::add_digit(c.major, b);
                    n_raw.state = hpr_pkg::ST_MAJOR;
                end
            end
            hpr_pkg::ST_MAJOR: begin
                if (b == hpr_pkg::CH_DOT) n_raw.state = hpr_pkg::ST_MINOR_START;
                else if (hpr_pkg::is_dec(b)) n_raw.major = hpr_pkg::add_digit(c.major, b);
            end
            hpr_pkg::ST_MINOR_START: begin
                if (hpr_pkg::is_dec(b)) begin
                    n_raw.minor = hpr_pkg::add_digit(c.minor, b);
                    n_raw.state = hpr_pkg::ST_MINOR;
                end
            end
            hpr_pkg::ST_MINOR: begin
                if (b == hpr_pkg::CH_CR) n_raw.state = hpr_pkg::ST_NL1;
                else if (hpr_pkg::is_dec(b)) n_raw.minor = hpr_pkg::add_digit(c.minor, b);
            end
            hpr_pkg::ST_NL1: begin
                if (b == hpr_pkg::CH_LF) n_raw.state = hpr_pkg::ST_LINE_START;
            end
            hpr_pkg::ST_LINE_START: begin
                if (b == hpr_pkg::CH_CR) begin
                    n_raw.state = hpr_pkg::ST_NL3;
                end else if (c.seen_header && (b == hpr_pkg::CH_SP || b == hpr_pkg::CH_TAB)) begin
                    n_raw.state = hpr_pkg::ST_LWS;
                end else if (hpr_pkg::is_token(b)) begin
                    n_raw.seen_header = 1'b1;
                    n_raw.is_host     = (b == hpr_pkg::HOST_TEXT[0]);
                    n_raw.match_pos   = (b == hpr_pkg::HOST_TEXT[0]) ? 3'd1 : 3'd0;
                    n_raw.state       = hpr_pkg::ST_NAME;
                end
            end
            hpr_pkg::ST_LWS: begin
                if (b == hpr_pkg::CH_CR) n_raw.state = hpr_pkg::ST_NL2;
                else if (b != hpr_pkg::CH_SP && b != hpr_pkg::CH_TAB && !hpr_pkg::is_ctl(b))
                    n_raw.state = hpr_pkg::ST_VALUE;
            end
            hpr_pkg::ST_NAME: begin
                if (b == hpr_pkg::CH_COLON) begin
                    n_raw.is_host = c.is_host && (c.match_pos == hpr_pkg::HOST_LEN);
                    n_raw.state   = hpr_pkg::ST_SP_VALUE;
                end else if (hpr_pkg::is_token(b)) begin
                    if (c.is_host && (c.match_pos < hpr_pkg::HOST_LEN)
                        && (b == hpr_pkg::HOST_TEXT[c.match_pos[1:0]]))
                        n_raw.match_pos = c.match_pos + 3'd1;
                    else
                        n_raw.is_host = 1'b0;
                end
            end
            hpr_pkg::ST_SP_VALUE: begin
                if (b == hpr_pkg::CH_SP) n_raw.state = hpr_pkg::ST_VALUE;
            end
            hpr_pkg::ST_VALUE: begin
                if (b == hpr_pkg::CH_CR) n_raw.state = hpr_pkg::ST_NL2;
            end
            hpr_pkg::ST_NL2: begin
                if (b == hpr_pkg::CH_LF) n_raw.state = hpr_pkg::ST_LINE_START;
            end
            hpr_pkg::ST_NL3: begin
                n_raw.state = hpr_pkg::ST_NL3;
            end
            default: begin
                n_raw = c;
            end
        endcase
    end

    always_comb begin
        sts    = hpr_pkg::STS_PENDING;
        role   = hpr_pkg::ROLE_OTHER;
        hbegin = 1'b0;
        hval   = 1'b0;
        unique case (c.state)
            hpr_pkg::ST_METHOD_START: begin
                if (hpr_pkg::is_token(b)) role = hpr_pkg::ROLE_METHOD;
                else sts = hpr_pkg::STS_BAD;
            end
            hpr_pkg::ST_METHOD: begin
                if (b == hpr_pkg::CH_SP) role = hpr_pkg::ROLE_OTHER;
                else if (hpr_pkg::is_token(b)) role = hpr_pkg::ROLE_METHOD;
                else sts = hpr_pkg::STS_BAD;
            end
            hpr_pkg::ST_URI: begin
                if (b == hpr_pkg::CH_SP) role = hpr_pkg::ROLE_OTHER;
                else if (hpr_pkg::is_ctl(b)) sts = hpr_pkg::STS_BAD;
                else role = hpr_pkg::ROLE_URI;
            end
            hpr_pkg::ST_VER_H: begin
                if (b != hpr_pkg::CH_H) sts = hpr_pkg::STS_BAD;
            end
            hpr_pkg::ST_VER_T1, hpr_pkg::ST_VER_T2: begin
                if (b != hpr_pkg::CH_T) sts = hpr_pkg::STS_BAD;
            end
            hpr_pkg::ST_VER_P: begin
                if (b != hpr_pkg::CH_P) sts = hpr_pkg::STS_BAD;
            end
            hpr_pkg::ST_VER_SLASH: begin
                if (b != hpr_pkg::CH_SLASH) sts = hpr_pkg::STS_BAD;
            end
            hpr_pkg::ST_MAJOR_START, hpr_pkg::ST_MINOR_START: begin
                if (!hpr_pkg::is_dec(b)) sts = hpr_pkg::STS_BAD;
            end
            hpr_pkg::ST_MAJOR: begin
                if (b != hpr_pkg::CH_DOT && !hpr_pkg::is_dec(b)) sts = hpr_pkg::STS_BAD;
            end
            hpr_pkg::ST_MINOR: begin
                if (b != hpr_pkg::CH_CR && !hpr_pkg::is_dec(b)) sts = hpr_pkg::STS_BAD;
            end
            hpr_pkg::ST_NL1, hpr_pkg::ST_NL2: begin
                if (b != hpr_pkg::CH_LF) sts = hpr_pkg::STS_BAD;
            end
            hpr_pkg::ST_LINE_START: begin
                if (b == hpr_pkg::CH_CR) begin
                    sts = hpr_pkg::STS_PENDING;
                end else if (c.seen_header && (b == hpr_pkg::CH_SP || b == hpr_pkg::CH_TAB)) begin
                    sts = hpr_pkg::STS_PENDING;
                end else if (hpr_pkg::is_token(b)) begin
                    role   = hpr_pkg::ROLE_NAME;
                    hbegin = 1'b1;
                end else begin
                    sts = hpr_pkg::STS_BAD;
                end
            end
            hpr_pkg::ST_LWS: begin
                if (b == hpr_pkg::CH_CR || b == hpr_pkg::CH_SP || b == hpr_pkg::CH_TAB) begin
                    sts = hpr_pkg::STS_PENDING;
                end else if (hpr_pkg::is_ctl(b)) begin
                    sts = hpr_pkg::STS_BAD;
                end else begin
                    role = hpr_pkg::ROLE_VALUE;
                    hval = c.is_host;
                end
            end
            hpr_pkg::ST_NAME: begin
                if (b == hpr_pkg::CH_COLON) role = hpr_pkg::ROLE_OTHER;
                else if (hpr_pkg::is_token(b)) role = hpr_pkg::ROLE_NAME;
                else sts = hpr_pkg::STS_BAD;
            end
            hpr_pkg::ST_SP_VALUE: begin
                if (b != hpr_pkg::CH_SP) sts = hpr_pkg::STS_BAD;
            end
            hpr_pkg::ST_VALUE: begin
                if (b == hpr_pkg::CH_CR) begin
                    sts = hpr_pkg::STS_PENDING;
                end else if (hpr_pkg::is_ctl(b)) begin
                    sts = hpr_pkg::STS_BAD;
                end else begin
                    role = hpr_pkg::ROLE_VALUE;
                    hval = c.is_host;
                end
            end
            hpr_pkg::ST_NL3: begin
                sts = (b == hpr_pkg::CH_LF) ? hpr_pkg::STS_GOOD : hpr_pkg::STS_BAD;
            end
            default: begin
                sts = hpr_pkg::STS_BAD;
            end
        endcase
    end

    assign o_ctx = (sts != hpr_pkg::STS_PENDING) ? hpr_pkg::CTX_RESET : n_raw;

    assign o_res = '{
        status:          sts,
        role:            role,
        header_begin:    hbegin,
        host_value_byte: hval,
        major:           n_raw.major,
        minor:           n_raw.minor
    };

endmodule

/* sv/hpr_chk.sv */
`timescale 1ns / 1ps
// Port checker for the HTTP request header parser, bound to the top level.
// Depends on http_request_header_parser_core port names only.
module hpr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("undefined status code");

    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == 2'd2 |-> m_axis_tdata[6:2] == 5'd0)
        else $error("rejected byte carries a role or flag");

    a_begin_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[4:2] == 3'd3)
        else $error("header begin outside header name");

    a_host_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[4:2] == 3'd4)
        else $error("host byte outside header value");

endmodule

bind http_request_header_parser_core hpr_chk u_hpr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for http_request_header_parser_core: streams request bytes,
// predicts every result word from its own byte-level grammar model and compares them.
// Depends on hpr_pkg and the parser RTL.
module testbench;
    import hpr_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;   // [0] start_of_request
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [1:0] status, [4:2] byte_role, [5] header_begin,
                                        // [6] host_value_byte, [14:7] version_major,
                                        // [22:15] version_minor, [23] zero

    logic [7:0] byte_q[$];
    bit         sor_q[$];
    bit         drain_q[$];
    t_res       expected_q[$];
    t_ctx       grammar;
    bit         drain_next = 1'b0;
    bit         garble = 1'b0;
    bit         in_taken = 1'b0;
    int         errors = 0;
    int         src_gap = 0;
    int         snk_gap = 0;
    int         src_mode = 0;
    int         snk_mode = 0;
    int         cyc = 0;

    http_request_header_parser_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit ctl_byte(input logic [7:0] b);
        return (b < 8'd32) || (b == CH_DEL);
    endfunction

    function automatic bit tchar(input logic [7:0] b);
        bit sep;
        case (b)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
            "/", "[", "]", "?", "=", "{", "}", " ", "\t": sep = 1'b1;
            default: sep = 1'b0;
        endcase
        return (b < 8'd128) && !ctl_byte(b) && !sep;
    endfunction

    function automatic bit digit_byte(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic [7:0] ver_accum(input logic [7:0] v, input logic [7:0] b);
        int n;
        n = int'(v) * 10 + int'(b) - int'(CH_ZERO);
        return (n > 255) ? 8'd255 : n[7:0];
    endfunction

    // advance the grammar by one byte and return the result word it yields
    function automatic t_res parse_byte(input logic [7:0] b, input bit sor);
        t_res r;
        r.status = STS_PENDING;
        r.role = ROLE_OTHER;
        r.header_begin = 1'b0;
        r.host_value_byte = 1'b0;
        if (sor) grammar = CTX_RESET;
        case (grammar.state)
            ST_METHOD_START: begin
                if (tchar(b)) begin
                    grammar.state = ST_METHOD;
                    r.role = ROLE_METHOD;
                end else r.status = STS_BAD;
            end
            ST_METHOD: begin
                if (b == CH_SP) grammar.state = ST_URI;
                else if (tchar(b)) r.role = ROLE_METHOD;
                else r.status = STS_BAD;
            end
            ST_URI: begin
                if (b == CH_SP) grammar.state = ST_VER_H;
                else if (ctl_byte(b)) r.status = STS_BAD;
                else r.role = ROLE_URI;
            end
            ST_VER_H: begin
                if (b == CH_H) grammar.state = ST_VER_T1; else r.status = STS_BAD;
            end
            ST_VER_T1: begin
                if (b == CH_T) grammar.state = ST_VER_T2; else r.status = STS_BAD;
            end
            ST_VER_T2: begin
                if (b == CH_T) grammar.state = ST_VER_P; else r.status = STS_BAD;
            end
            ST_VER_P: begin
                if (b == CH_P) grammar.state = ST_VER_SLASH; else r.status = STS_BAD;
            end
            ST_VER_SLASH: begin
                if (b == CH_SLASH) begin
                    grammar.major = 8'd0;
                    grammar.minor = 8'd0;
                    grammar.state = ST_MAJOR_START;
                end else r.status = STS_BAD;
            end
            ST_MAJOR_START: begin
                if (digit_byte(b)) begin
                    grammar.major = ver_accum(grammar.major, b);
                    grammar.state = ST_MAJOR;
                end else r.status = STS_BAD;
            end
            ST_MAJOR: begin
                if (b == CH_DOT) grammar.state = ST_MINOR_START;
                else if (digit_byte(b)) grammar.major = ver_accum(grammar.major, b);
                else r.status = STS_BAD;
            end
            ST_MINOR_START: begin
                if (digit_byte(b)) begin
                    grammar.minor = ver_accum(grammar.minor, b);
                    grammar.state = ST_MINOR;
                end else r.status = STS_BAD;
            end
            ST_MINOR: begin
                if (b == CH_CR) grammar.state = ST_NL1;
                else if (digit_byte(b)) grammar.minor = ver_accum(grammar.minor, b);
                else r.status = STS_BAD;
            end
            ST_NL1: begin
                if (b == CH_LF) grammar.state = ST_LINE_START; else r.status = STS_BAD;
            end
            ST_LINE_START: begin
                if (b == CH_CR) grammar.state = ST_NL3;
                else if (grammar.seen_header && (b == CH_SP || b == CH_TAB))
                    grammar.state = ST_LWS;
                else if (tchar(b)) begin
                    grammar.seen_header = 1'b1;
                    grammar.is_host = (b == HOST_TEXT[0]);
                    grammar.match_pos = grammar.is_host ? 3'd1 : 3'd0;
                    grammar.state = ST_NAME;
                    r.role = ROLE_NAME;
                    r.header_begin = 1'b1;
                end else r.status = STS_BAD;
            end
            ST_LWS: begin
                if (b == CH_CR) grammar.state = ST_NL2;
                else if (b == CH_SP || b == CH_TAB) r.role = ROLE_OTHER;
                else if (ctl_byte(b)) r.status = STS_BAD;
                else begin
                    grammar.state = ST_VALUE;
                    r.role = ROLE_VALUE;
                    r.host_value_byte = grammar.is_host;
                end
            end
            ST_NAME: begin
                if (b == CH_COLON) begin
                    grammar.is_host = grammar.is_host && (grammar.match_pos == HOST_LEN);
                    grammar.state = ST_SP_VALUE;
                end else if (tchar(b)) begin
                    r.role = ROLE_NAME;
                    if (grammar.is_host && grammar.match_pos < HOST_LEN
                        && b == HOST_TEXT[grammar.match_pos[1:0]])
                        grammar.match_pos = grammar.match_pos + 3'd1;
                    else
                        grammar.is_host = 1'b0;
                end else r.status = STS_BAD;
            end
            ST_SP_VALUE: begin
                if (b == CH_SP) grammar.state = ST_VALUE; else r.status = STS_BAD;
            end
            ST_VALUE: begin
                if (b == CH_CR) grammar.state = ST_NL2;
                else if (ctl_byte(b)) r.status = STS_BAD;
                else begin
                    r.role = ROLE_VALUE;
                    r.host_value_byte = grammar.is_host;
                end
            end
            ST_NL2: begin
                if (b == CH_LF) grammar.state = ST_LINE_START; else r.status = STS_BAD;
            end
            ST_NL3: begin
                r.status = (b == CH_LF) ? STS_GOOD : STS_BAD;
            end
            default: r.status = STS_BAD;
        endcase
        r.major = grammar.major;
        r.minor = grammar.minor;
        if (r.status != STS_PENDING) grammar = CTX_RESET;
        return r;
    endfunction

    task automatic put(input logic [7:0] b, input bit sor);
        logic [7:0] v;
        bit         s;
        v = b;
        s = sor;
        if (garble && $urandom_range(0, 39) == 0) v = 8'($urandom_range(0, 255));
        if (garble && $urandom_range(0, 99) == 0) s = 1'b1;
        byte_q = {byte_q, v};
        sor_q = {sor_q, s};
        drain_q = {drain_q, drain_next};
        drain_next = 1'b0;
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) put(s[i], 1'b0);
    endtask

    function automatic logic [7:0] rand_tchar();
        logic [7:0] c;
        c = 8'($urandom_range(33, 126));
        while (!tchar(c)) c = 8'($urandom_range(33, 126));
        return c;
    endfunction

    function automatic logic [7:0] rand_text();
        logic [7:0] c;
        c = 8'($urandom_range(32, 255));
        while (c == CH_DEL) c = 8'($urandom_range(32, 255));
        return c;
    endfunction

    task automatic put_digits();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2);
        repeat (n) put(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
    endtask

    task automatic put_request();
        int n;
        garble = ($urandom_range(0, 3) == 0);
        put(rand_tchar(), $urandom_range(0, 1));
        repeat ($urandom_range(0, 5)) put(rand_tchar(), 1'b0);
        put(CH_SP, 1'b0);
        repeat ($urandom_range(1, 8)) put(($urandom_range(0, 1) != 0) ? rand_text()
                                          : rand_tchar(), 1'b0);
        put_str(" HTTP/");
        put_digits();
        put(CH_DOT, 1'b0);
        put_digits();
        put_str("\r\n");
        n = $urandom_range(0, 4);
        repeat (n) begin
            case ($urandom_range(0, 5))
                0, 1: put_str("Host");
                2: put_str("host");
                3: put_str("Hos");
                4: put_str("Hostx");
                default: repeat ($urandom_range(1, 6)) put(rand_tchar(), 1'b0);
            endcase
            put_str(": ");
            repeat ($urandom_range(0, 6)) put(rand_text(), 1'b0);
            put_str("\r\n");
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 2)) put(($urandom_range(0, 1) != 0) ? CH_SP
                                                  : CH_TAB, 1'b0);
                repeat ($urandom_range(0, 4)) put(rand_text(), 1'b0);
                put_str("\r\n");
            end
        end
        put_str("\r\n");
        garble = 1'b0;
    endtask

    // stimulus and end of run
    initial begin
        grammar = CTX_RESET;
        put(8'h00, 1'b1);
        put(8'hFF, 1'b0);
        put_str("A ");
        put(8'h80, 1'b0);
        put_str(" HTTP/999.256\r\nHost: ");
        put(8'hFF, 1'b0);
        put_str("\r\n\r\n");
        drain_next = 1'b1;
        while (byte_q.size() < 560) begin
            if ($urandom_range(0, 49) == 0) drain_next = 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 5)) put(8'($urandom_range(0, 255)),
                                                  $urandom_range(0, 3) == 0);
            else
                put_request();
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (byte_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("http_request_header_parser_core regression: pass");
        else
            $display("http_request_header_parser_core regression: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("http_request_header_parser_core regression: fail");
        $finish;
    end

    // driver: both sides change at the falling edge
    always @(negedge i_clk) begin
        logic       v;
        logic [7:0] d;
        logic       u;
        logic       rdy;
        bit         quiet;
        v = s_axis_tvalid;
        d = s_axis_tdata;
        u = s_axis_tuser;
        rdy = 1'b0;
        quiet = byte_q.size() < 80;
        if (i_rst_n) begin
            cyc++;
            if (cyc % 64 == 0) begin
                src_mode = $urandom_range(0, 2);
                snk_mode = $urandom_range(0, 2);
            end
            if (s_axis_tvalid && in_taken) v = 1'b0;
            if (!v) begin
                if (src_gap > 0 && !quiet) src_gap--;
                else if (byte_q.size() > 0 && !(drain_q[0] && expected_q.size() > 0)) begin
                    d = byte_q.pop_front();
                    u = sor_q.pop_front();
                    void'(drain_q.pop_front());
                    v = 1'b1;
                    if (src_mode != 0 && $urandom_range(0, src_mode == 1 ? 7 : 2) == 0)
                        src_gap = $urandom_range(1, 18);
                end
            end
            if (snk_gap > 0 && !quiet) begin
                snk_gap--;
            end else begin
                snk_gap = 0;
                rdy = 1'b1;
                if (snk_mode != 0 && $urandom_range(0, snk_mode == 1 ? 7 : 2) == 0)
                    snk_gap = $urandom_range(1, 18);
            end
        end
        s_axis_tvalid <= v;
        s_axis_tdata <= d;
        s_axis_tuser <= u;
        m_axis_tready <= rdy;
    end

    // monitor: sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = t_status'(m_axis_tdata[1:0]);
                got.role = t_role'(m_axis_tdata[4:2]);
                got.header_begin = m_axis_tdata[5];
                got.host_value_byte = m_axis_tdata[6];
                got.major = m_axis_tdata[14:7];
                got.minor = m_axis_tdata[22:15];
                if (expected_q.size() == 0) begin
                    $error("unexpected result word 0x%06h", m_axis_tdata);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.role !== want.role) begin
                        $error("byte_role: expected %0d, actual %0d", want.role, got.role);
                        errors++;
                    end
                    if (got.header_begin !== want.header_begin) begin
                        $error("header_begin: expected %0d, actual %0d",
                               want.header_begin, got.header_begin);
                        errors++;
                    end
                    if (got.host_value_byte !== want.host_value_byte) begin
                        $error("host_value_byte: expected %0d, actual %0d",
                               want.host_value_byte, got.host_value_byte);
                        errors++;
                    end
                    if (got.major !== want.major) begin
                        $error("version_major: expected %0d, actual %0d",
                               want.major, got.major);
                        errors++;
                    end
                    if (got.minor !== want.minor) begin
                        $error("version_minor: expected %0d, actual %0d",
                               want.minor, got.minor);
                        errors++;
                    end
                end
            end
            in_taken = s_axis_tvalid && s_axis_tready;
            if (in_taken) expected_q = {expected_q, parse_byte(s_axis_tdata, s_axis_tuser)};
        end
    end

endmodule

/* filelist.f */
sv/hpr_pkg.sv
sv/hpr_step.sv
sv/http_request_header_parser_core.sv
sv/hpr_chk.sv
sim/testbench.sv
